>>> sv/segment_sphere_clip_assert.svh
// Assertion macros for the segment sphere clip block.
// Used by the checker file; needs nothing else.
`ifndef SEGMENT_SPHERE_CLIP_ASSERT_SVH
`define SEGMENT_SPHERE_CLIP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SSC_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ssc_pkg.sv
// Package for the segment sphere clip block: widths, outcome codes and the
// record that travels down the pipeline. Depends on nothing.
`default_nettype none

package ssc_pkg;

    localparam int COORD_W             = 31;
    localparam int WORD_W              = 32;
    localparam int RAD_W               = 30;
    localparam int OC_W                = 3;
    localparam int LANES               = 3;
    localparam int WIDE_W              = 64;
    localparam int ROOT_W              = WIDE_W / 2;
    localparam int CENTRE_DEADBAND_DEF = 32;

    typedef enum logic [OC_W-1:0] {
        OC_SAME    = 3'd0,
        OC_NEAR    = 3'd1,
        OC_PROJ    = 3'd2,
        OC_OUTWARD = 3'd3,
        OC_MISS    = 3'd4,
        OC_SHORT   = 3'd5,
        OC_HIT     = 3'd6
    } t_outcome;

    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] s;
        logic [LANES-1:0][WORD_W-1:0] t;
        logic [LANES-1:0][WORD_W-1:0] dv;
        logic [WORD_W-1:0]            tw;
        logic [WIDE_W-1:0]            ss;
        logic [WIDE_W-1:0]            rr;
        logic [LANES-1:0][WIDE_W-1:0] sr;
        logic [WIDE_W-1:0]            dot;
        logic                         in_sph;
        logic                         fin;
        t_outcome                     oc;
        logic [ROOT_W-1:0]            d;
        logic [ROOT_W-1:0]            mb;
        logic [LANES-1:0][WORD_W-1:0] p;
    } t_side;

endpackage

`default_nettype wire

>>> sv/ssc_if.sv
// Valid/ready channel interfaces for the segment sphere clip block.
// Depends on ssc_pkg for the field widths.
`default_nettype none

interface ssc_in_if;
    import ssc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  target_x;
    logic signed [COORD_W-1:0]  target_y;
    logic signed [COORD_W-1:0]  target_z;
    logic signed [WORD_W-1:0]   target_w;
    logic        [RAD_W-1:0]    radius;

    modport source (output valid, start_x, start_y, start_z, target_x, target_y,
                    target_z, target_w, radius, input ready);
    modport sink (input valid, start_x, start_y, start_z, target_x, target_y,
                  target_z, target_w, radius, output ready);
endinterface

interface ssc_out_if;
    import ssc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  out_x;
    logic signed [WORD_W-1:0]  out_y;
    logic signed [WORD_W-1:0]  out_z;
    logic signed [WORD_W-1:0]  out_w;
    logic        [OC_W-1:0]    outcome;

    modport source (output valid, out_x, out_y, out_z, out_w, outcome, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, outcome, output ready);
endinterface

`default_nettype wire

>>> sv/ssc_isqrt.sv
// Pipelined floor square root, one root bit per register stage, with a
// sideband record carried alongside. Depends on nothing outside itself.
`default_nettype none

module ssc_isqrt #(
    parameter int  IN_W   = 64,
    parameter type t_side = logic
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_arg,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output t_side               o_side
);

    localparam int STEPS = IN_W / 2;
    localparam int REM_W = STEPS + 3;

    logic              r_valid [1:STEPS];
    logic [IN_W-1:0]   r_v     [1:STEPS];
    logic [REM_W-1:0]  r_rem   [1:STEPS];
    logic [STEPS-1:0]  r_q     [1:STEPS];
    t_side             r_side  [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic             c_valid;
        logic [IN_W-1:0]  c_v;
        logic [REM_W-1:0] c_rem;
        logic [STEPS-1:0] c_q;
        t_side            c_side;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] n_rem;
        logic [STEPS-1:0] n_q;

        if (k == 0) begin : g_first
            assign c_valid = i_valid;
            assign c_v     = i_arg;
            assign c_rem   = '0;
            assign c_q     = '0;
            assign c_side  = i_side;
        end else begin : g_next
            assign c_valid = r_valid[k];
            assign c_v     = r_v[k];
            assign c_rem   = r_rem[k];
            assign c_q     = r_q[k];
            assign c_side  = r_side[k];
        end

        always_comb begin
            sh    = {c_rem[REM_W-3:0], c_v[IN_W-1 -: 2]};
            trial = {1'b0, c_q, 2'b01};
            if (sh >= trial) begin
                n_rem = sh - trial;
                n_q   = {c_q[STEPS-2:0], 1'b1};
            end else begin
                n_rem = sh;
                n_q   = {c_q[STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= c_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1]    <= {c_v[IN_W-3:0], 2'b00};
                r_rem[k+1]  <= n_rem;
                r_q[k+1]    <= n_q;
                r_side[k+1] <= c_side;
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_root  = r_q[STEPS];
    assign o_side  = r_side[STEPS];

endmodule

`default_nettype wire

>>> sv/ssc_div.sv
// Pipelined signed divider, several lanes sharing one positive divisor,
// one quotient bit per stage, truncating toward zero. Depends on nothing.
`default_nettype none

module ssc_div #(
    parameter int  LANES  = 3,
    parameter int  NUM_W  = 64,
    parameter int  DEN_W  = 32,
    parameter type t_side = logic
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]             i_den,
    input  t_side                        i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][NUM_W-1:0]  o_quo,
    output t_side                        o_side
);

    logic                         r_p_valid;
    logic [LANES-1:0][NUM_W-1:0]  r_p_mag;
    logic [LANES-1:0]             r_p_neg;
    logic [DEN_W-1:0]             r_p_den;
    t_side                        r_p_side;

    logic                         r_valid [1:NUM_W];
    logic [LANES-1:0][NUM_W-1:0]  r_acc   [1:NUM_W];
    logic [LANES-1:0][DEN_W-1:0]  r_rem   [1:NUM_W];
    logic [LANES-1:0]             r_neg   [1:NUM_W];
    logic [DEN_W-1:0]             r_den   [1:NUM_W];
    t_side                        r_side  [1:NUM_W];

    logic                         r_o_valid;
    logic [LANES-1:0][NUM_W-1:0]  r_o_quo;
    t_side                        r_o_side;

    logic [LANES-1:0][NUM_W-1:0]  n_p_mag;
    logic [LANES-1:0]             n_p_neg;
    logic [LANES-1:0][NUM_W-1:0]  n_o_quo;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_p_neg[l] = i_num[l][NUM_W-1];
            n_p_mag[l] = i_num[l][NUM_W-1] ? (~i_num[l] + 1'b1) : i_num[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_mag  <= n_p_mag;
            r_p_neg  <= n_p_neg;
            r_p_den  <= i_den;
            r_p_side <= i_side;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic                         c_valid;
        logic [LANES-1:0][NUM_W-1:0]  c_acc;
        logic [LANES-1:0][DEN_W-1:0]  c_rem;
        logic [LANES-1:0]             c_neg;
        logic [DEN_W-1:0]             c_den;
        t_side                        c_side;
        logic [LANES-1:0][DEN_W-1:0]  n_rem;
        logic [LANES-1:0][NUM_W-1:0]  n_acc;

        if (k == 0) begin : g_first
            assign c_valid = r_p_valid;
            assign c_acc   = r_p_mag;
            assign c_rem   = '0;
            assign c_neg   = r_p_neg;
            assign c_den   = r_p_den;
            assign c_side  = r_p_side;
        end else begin : g_next
            assign c_valid = r_valid[k];
            assign c_acc   = r_acc[k];
            assign c_rem   = r_rem[k];
            assign c_neg   = r_neg[k];
            assign c_den   = r_den[k];
            assign c_side  = r_side[k];
        end

        always_comb begin
            logic [DEN_W:0] sh;
            logic [DEN_W:0] diff;
            for (int l = 0; l < LANES; l++) begin
                sh   = {c_rem[l], c_acc[l][NUM_W-1]};
                diff = sh - {1'b0, c_den};
                if (sh >= {1'b0, c_den}) begin
                    n_rem[l] = diff[DEN_W-1:0];
                    n_acc[l] = {c_acc[l][NUM_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = sh[DEN_W-1:0];
                    n_acc[l] = {c_acc[l][NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= c_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1]  <= n_acc;
                r_rem[k+1]  <= n_rem;
                r_neg[k+1]  <= c_neg;
                r_den[k+1]  <= c_den;
                r_side[k+1] <= c_side;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_o_quo[l] = r_neg[NUM_W][l] ? (~r_acc[NUM_W][l] + 1'b1) : r_acc[NUM_W][l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_valid[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_quo  <= n_o_quo;
            r_o_side <= r_side[NUM_W];
        end
    end

    assign o_valid = r_o_valid;
    assign o_quo   = r_o_quo;
    assign o_side  = r_o_side;

endmodule

`default_nettype wire

>>> sv/segment_sphere_clip.sv
// Segment sphere clip: stops a straight move from S to T against a sphere of
// radius r centred at the origin.
// One valid/ready input channel carries S, T, the target w word and r; one
// valid/ready output channel carries the resulting point, w and the outcome.
// The block is a single pipeline of 208 register stages: four stages of
// products and sums, a 32-stage square root, one divisor stage, a 66-stage
// divider, four stages for the miss test, a second 32-stage square root, two
// stages for the stop distance, a second 66-stage divider and the output
// register. A new item is taken in every cycle unless the pipeline stalls; the
// throughput is one item per cycle.
// When the receiver holds off while the output register is full, the whole
// pipeline stands still and the input ready drops, so nothing is lost or
// repeated. Synchronous reset clears every valid bit; the data registers
// keep whatever they hold.
// Depends on ssc_pkg, ssc_if, ssc_isqrt and ssc_div.
`default_nettype none

module segment_sphere_clip #(
    parameter int CENTRE_DEADBAND = ssc_pkg::CENTRE_DEADBAND_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_in_if.sink    i_in,
    ssc_out_if.source o_out
);
    import ssc_pkg::*;

    localparam logic [WIDE_W-1:0] DB_SQ =
        WIDE_W'(CENTRE_DEADBAND) * WIDE_W'(CENTRE_DEADBAND);

    logic en;

    logic                          r_s1_valid;
    t_side                         r_s1_side;
    logic [RAD_W-1:0]              r_s1_r;
    t_side                         n_s1_side;

    logic                          r_s2_valid;
    t_side                         r_s2_side;
    logic [LANES-1:0][WIDE_W-1:0]  r_s2_sqs;
    logic [LANES-1:0][WIDE_W-1:0]  r_s2_sqd;
    logic [LANES-1:0][WIDE_W-1:0]  r_s2_sd;
    t_side                         n_s2_side;
    logic [LANES-1:0][WIDE_W-1:0]  n_s2_sqs;
    logic [LANES-1:0][WIDE_W-1:0]  n_s2_sqd;
    logic [LANES-1:0][WIDE_W-1:0]  n_s2_sd;

    logic                          r_s3_valid;
    t_side                         r_s3_side;
    logic [WIDE_W-1:0]             r_s3_dd;
    t_side                         n_s3_side;

    logic                          r_s4_valid;
    t_side                         r_s4_side;
    logic [WIDE_W-1:0]             r_s4_arg;
    t_side                         n_s4_side;

    logic                          sq1_valid;
    logic [ROOT_W-1:0]             sq1_root;
    t_side                         sq1_side;

    logic                          r_s5_valid;
    t_side                         r_s5_side;
    logic [LANES-1:0][WIDE_W-1:0]  r_s5_num;
    t_side                         n_s5_side;
    logic [LANES-1:0][WIDE_W-1:0]  n_s5_num;

    logic                          dv1_valid;
    logic [LANES-1:0][WIDE_W-1:0]  dv1_quo;
    t_side                         dv1_side;

    logic                          r_s6_valid;
    t_side                         r_s6_side;
    t_side                         n_s6_side;

    logic                          r_s7_valid;
    t_side                         r_s7_side;
    logic [WIDE_W-1:0]             r_s7_bb;

    logic                          r_s8_valid;
    t_side                         r_s8_side;
    logic                          r_s8_le;
    logic [WIDE_W-1:0]             r_s8_a;
    logic [WIDE_W-1:0]             r_s8_b;

    logic                          r_s9_valid;
    t_side                         r_s9_side;
    logic [WIDE_W-1:0]             r_s9_arg;
    t_side                         n_s9_side;

    logic                          sq2_valid;
    logic [ROOT_W-1:0]             sq2_root;
    t_side                         sq2_side;

    logic                          r_s10_valid;
    t_side                         r_s10_side;
    logic [ROOT_W-1:0]             r_s10_k;

    logic                          r_s11_valid;
    t_side                         r_s11_side;
    logic [LANES-1:0][WIDE_W-1:0]  r_s11_num;
    t_side                         n_s11_side;
    logic [LANES-1:0][WIDE_W-1:0]  n_s11_num;

    logic                          dv2_valid;
    logic [LANES-1:0][WIDE_W-1:0]  dv2_quo;
    t_side                         dv2_side;

    logic                          r_out_valid;
    logic [WORD_W-1:0]             r_out_x;
    logic [WORD_W-1:0]             r_out_y;
    logic [WORD_W-1:0]             r_out_z;
    logic [WORD_W-1:0]             r_out_w;
    t_outcome                      r_out_oc;
    logic [LANES-1:0][WORD_W-1:0]  n_out_p;
    logic [WORD_W-1:0]             n_out_w;
    t_outcome                      n_out_oc;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // Operand capture: sign extension, move vector and the equal-points test.
    always_comb begin
        n_s1_side      = '0;
        n_s1_side.s[0] = {i_in.start_x[COORD_W-1], i_in.start_x};
        n_s1_side.s[1] = {i_in.start_y[COORD_W-1], i_in.start_y};
        n_s1_side.s[2] = {i_in.start_z[COORD_W-1], i_in.start_z};
        n_s1_side.t[0] = {i_in.target_x[COORD_W-1], i_in.target_x};
        n_s1_side.t[1] = {i_in.target_y[COORD_W-1], i_in.target_y};
        n_s1_side.t[2] = {i_in.target_z[COORD_W-1], i_in.target_z};
        n_s1_side.tw   = i_in.target_w;
        for (int i = 0; i < LANES; i++) begin
            n_s1_side.dv[i] = n_s1_side.t[i] - n_s1_side.s[i];
        end
        n_s1_side.fin = (i_in.start_x == i_in.target_x) &&
                        (i_in.start_y == i_in.target_y) &&
                        (i_in.start_z == i_in.target_z);
        n_s1_side.oc  = OC_SAME;
    end

    // Products.
    always_comb begin
        logic signed [WIDE_W-1:0] sv;
        logic signed [WIDE_W-1:0] dvv;
        logic signed [WIDE_W-1:0] rv;
        n_s2_side = r_s1_side;
        rv        = $signed({{(WIDE_W-RAD_W){1'b0}}, r_s1_r});
        for (int i = 0; i < LANES; i++) begin
            sv  = WIDE_W'($signed(r_s1_side.s[i]));
            dvv = WIDE_W'($signed(r_s1_side.dv[i]));
            n_s2_sqs[i]     = sv * sv;
            n_s2_sqd[i]     = dvv * dvv;
            n_s2_sd[i]      = sv * dvv;
            n_s2_side.sr[i] = sv * rv;
        end
        n_s2_side.rr = WIDE_W'(r_s1_r) * WIDE_W'(r_s1_r);
    end

    // Sums of squares and the dot product.
    always_comb begin
        n_s3_side     = r_s2_side;
        n_s3_side.ss  = r_s2_sqs[0] + r_s2_sqs[1] + r_s2_sqs[2];
        n_s3_side.dot = r_s2_sd[0] + r_s2_sd[1] + r_s2_sd[2];
    end

    // Inside test picks which length goes to the first root; also the near-centre test.
    always_comb begin
        n_s4_side        = r_s3_side;
        n_s4_side.in_sph = r_s3_side.ss < r_s3_side.rr;
        if (!r_s3_side.fin && n_s4_side.in_sph && (r_s3_side.ss < DB_SQ)) begin
            n_s4_side.fin = 1'b1;
            n_s4_side.oc  = OC_NEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= n_s1_side;
            r_s1_r    <= i_in.radius;
            r_s2_side <= n_s2_side;
            r_s2_sqs  <= n_s2_sqs;
            r_s2_sqd  <= n_s2_sqd;
            r_s2_sd   <= n_s2_sd;
            r_s3_side <= n_s3_side;
            r_s3_dd   <= r_s2_sqd[0] + r_s2_sqd[1] + r_s2_sqd[2];
            r_s4_side <= n_s4_side;
            r_s4_arg  <= n_s4_side.in_sph ? r_s3_side.ss : r_s3_dd;
        end
    end

    ssc_isqrt #(
        .IN_W   (WIDE_W),
        .t_side (t_side)
    ) u_sqrt1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_valid),
        .i_arg   (r_s4_arg),
        .i_side  (r_s4_side),
        .o_valid (sq1_valid),
        .o_root  (sq1_root),
        .o_side  (sq1_side)
    );

    // Divisor and dividends for the first division.
    always_comb begin
        n_s5_side   = sq1_side;
        n_s5_side.d = (sq1_root == '0) ? ROOT_W'(1) : sq1_root;
        if (sq1_side.in_sph) begin
            n_s5_num = sq1_side.sr;
        end else begin
            n_s5_num    = '0;
            n_s5_num[0] = sq1_side.dot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s5_valid <= sq1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_side <= n_s5_side;
            r_s5_num  <= n_s5_num;
        end
    end

    ssc_div #(
        .LANES  (LANES),
        .NUM_W  (WIDE_W),
        .DEN_W  (ROOT_W),
        .t_side (t_side)
    ) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s5_valid),
        .i_num   (r_s5_num),
        .i_den   (r_s5_side.d),
        .i_side  (r_s5_side),
        .o_valid (dv1_valid),
        .o_quo   (dv1_quo),
        .o_side  (dv1_side)
    );

    // Projection result, or the signed projection b of S on the move and the outward test.
    always_comb begin
        logic [WIDE_W-1:0] nb;
        n_s6_side = dv1_side;
        nb        = ~dv1_quo[0] + 1'b1;
        n_s6_side.mb = nb[ROOT_W-1:0];
        for (int i = 0; i < LANES; i++) begin
            n_s6_side.p[i] = dv1_quo[i][WORD_W-1:0];
        end
        if (!dv1_side.fin) begin
            if (dv1_side.in_sph) begin
                n_s6_side.fin = 1'b1;
                n_s6_side.oc  = OC_PROJ;
            end else if (!dv1_quo[0][WIDE_W-1] && (dv1_quo[0] != '0)) begin
                n_s6_side.fin = 1'b1;
                n_s6_side.oc  = OC_OUTWARD;
            end
        end
    end

    always_comb begin
        n_s9_side = r_s8_side;
        if (!r_s8_side.fin && r_s8_le && (r_s8_a > r_s8_side.rr)) begin
            n_s9_side.fin = 1'b1;
            n_s9_side.oc  = OC_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
            r_s9_valid <= 1'b0;
        end else if (en) begin
            r_s6_valid <= dv1_valid;
            r_s7_valid <= r_s6_valid;
            r_s8_valid <= r_s7_valid;
            r_s9_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_side <= n_s6_side;
            r_s7_side <= r_s6_side;
            r_s7_bb   <= WIDE_W'(r_s6_side.mb) * WIDE_W'(r_s6_side.mb);
            r_s8_side <= r_s7_side;
            r_s8_le   <= r_s7_bb <= r_s7_side.ss;
            r_s8_a    <= r_s7_side.ss - r_s7_bb;
            r_s8_b    <= r_s7_bb - r_s7_side.ss;
            r_s9_side <= n_s9_side;
            r_s9_arg  <= r_s8_le ? (r_s8_side.rr - r_s8_a) : (r_s8_side.rr + r_s8_b);
        end
    end

    ssc_isqrt #(
        .IN_W   (WIDE_W),
        .t_side (t_side)
    ) u_sqrt2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s9_valid),
        .i_arg   (r_s9_arg),
        .i_side  (r_s9_side),
        .o_valid (sq2_valid),
        .o_root  (sq2_root),
        .o_side  (sq2_side)
    );

    // Stop distance k, the short test and the scaled move vector.
    always_comb begin
        logic signed [WIDE_W:0] prod;
        n_s11_side = r_s10_side;
        if (!r_s10_side.fin && (r_s10_k > r_s10_side.d)) begin
            n_s11_side.fin = 1'b1;
            n_s11_side.oc  = OC_SHORT;
        end
        for (int i = 0; i < LANES; i++) begin
            prod         = $signed(r_s10_side.dv[i]) * $signed({1'b0, r_s10_k});
            n_s11_num[i] = prod[WIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_valid <= 1'b0;
            r_s11_valid <= 1'b0;
        end else if (en) begin
            r_s10_valid <= sq2_valid;
            r_s11_valid <= r_s10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s10_side <= sq2_side;
            r_s10_k    <= (sq2_side.mb >= sq2_root) ? (sq2_side.mb - sq2_root) : '0;
            r_s11_side <= n_s11_side;
            r_s11_num  <= n_s11_num;
        end
    end

    ssc_div #(
        .LANES  (LANES),
        .NUM_W  (WIDE_W),
        .DEN_W  (ROOT_W),
        .t_side (t_side)
    ) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s11_valid),
        .i_num   (r_s11_num),
        .i_den   (r_s11_side.d),
        .i_side  (r_s11_side),
        .o_valid (dv2_valid),
        .o_quo   (dv2_quo),
        .o_side  (dv2_side)
    );

    always_comb begin
        n_out_oc = dv2_side.fin ? dv2_side.oc : OC_HIT;
        n_out_w  = '0;
        unique case (n_out_oc)
            OC_SAME, OC_NEAR: begin
                n_out_p = dv2_side.s;
            end
            OC_PROJ: begin
                n_out_p = dv2_side.p;
            end
            OC_OUTWARD: begin
                n_out_p = dv2_side.t;
            end
            OC_MISS, OC_SHORT: begin
                n_out_p = dv2_side.t;
                n_out_w = dv2_side.tw;
            end
            OC_HIT: begin
                for (int i = 0; i < LANES; i++) begin
                    n_out_p[i] = dv2_quo[i][WORD_W-1:0] + dv2_side.s[i];
                end
            end
            default: begin
                n_out_p = dv2_side.t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x  <= n_out_p[0];
            r_out_y  <= n_out_p[1];
            r_out_z  <= n_out_p[2];
            r_out_w  <= n_out_w;
            r_out_oc <= n_out_oc;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.out_x   = r_out_x;
    assign o_out.out_y   = r_out_y;
    assign o_out.out_z   = r_out_z;
    assign o_out.out_w   = r_out_w;
    assign o_out.outcome = r_out_oc;

endmodule

`default_nettype wire

>>> sv/ssc_checker.sv
// Port-level checker for the segment sphere clip block, bound to the top level.
// Depends on ssc_pkg and the assertion macro header.
`default_nettype none

`include "segment_sphere_clip_assert.svh"

module ssc_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [ssc_pkg::WORD_W-1:0] i_out_w,
    input wire logic [ssc_pkg::OC_W-1:0]   i_outcome
);
    import ssc_pkg::*;

    `SSC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `SSC_ASSERT(a_ready_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input refused with empty output")
    `SSC_ASSERT(a_w_only_target, i_clk, i_rst_n, i_out_valid && !(i_outcome == OC_MISS || i_outcome == OC_SHORT) |-> i_out_w == '0, "w word on a result that does not return the target")
    `SSC_ASSERT_ALL(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result shown after reset")

endmodule

bind segment_sphere_clip ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_w     (o_out.out_w),
    .i_outcome   (o_out.outcome)
);

`default_nettype wire

>>> sim/tb.sv
// Testbench for segment_sphere_clip: directed table of moves followed by random
// moves, each result checked against a table value or a behavioural predictor here.
// Depends on ssc_pkg, ssc_if and the RTL of the block.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssc_pkg::*;

    localparam int LATENCY   = 208;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1950;
    localparam longint unsigned DEADBAND = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx, sy, sz, tx, ty, tz;
        logic signed [WORD_W-1:0]  tw;
        logic        [RAD_W-1:0]   r;
    } t_move;

    typedef struct packed {
        logic signed [WORD_W-1:0] x, y, z, w;
        t_outcome                 oc;
    } t_point;

    typedef struct {
        t_move  mv;
        bit     typed;
        t_point res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    ssc_in_if  in_ch ();
    ssc_out_if out_ch ();

    segment_sphere_clip dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_point clip_queue[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    bit     stim_done = 1'b0;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sq_mag(longint a);
        longint unsigned u;
        u = (a < 0) ? longint'(-a) : a;
        return u * u;
    endfunction

    function automatic t_point mk_point(longint x, longint y, longint z, longint w,
                                        t_outcome oc);
        t_point p;
        p.x = x[31:0];
        p.y = y[31:0];
        p.z = z[31:0];
        p.w = w[31:0];
        p.oc = oc;
        return p;
    endfunction

    function automatic t_point clip_move(t_move mv);
        longint s[3], t[3], dv[3], p[3];
        longint r, sl, dot, b;
        longint unsigned ss, rr, dd, d, bb, k, root;
        s[0] = mv.sx; s[1] = mv.sy; s[2] = mv.sz;
        t[0] = mv.tx; t[1] = mv.ty; t[2] = mv.tz;
        r = longint'({34'd0, mv.r});
        if (s[0] == t[0] && s[1] == t[1] && s[2] == t[2])
            return mk_point(s[0], s[1], s[2], 0, OC_SAME);
        ss = sq_mag(s[0]) + sq_mag(s[1]) + sq_mag(s[2]);
        rr = r * r;
        if (ss < rr) begin
            if (ss < DEADBAND * DEADBAND)
                return mk_point(s[0], s[1], s[2], 0, OC_NEAR);
            sl = floor_root(ss);
            if (sl == 0) sl = 1;
            for (int i = 0; i < 3; i++) p[i] = (s[i] * r) / sl;
            return mk_point(p[0], p[1], p[2], 0, OC_PROJ);
        end
        for (int i = 0; i < 3; i++) dv[i] = t[i] - s[i];
        dd = sq_mag(dv[0]) + sq_mag(dv[1]) + sq_mag(dv[2]);
        d = floor_root(dd);
        if (d == 0) d = 1;
        dot = s[0] * dv[0] + s[1] * dv[1] + s[2] * dv[2];
        b = dot / longint'(d);
        if (b > 0)
            return mk_point(t[0], t[1], t[2], 0, OC_OUTWARD);
        bb = sq_mag(b);
        if (bb <= ss && ss - bb > rr)
            return mk_point(t[0], t[1], t[2], mv.tw, OC_MISS);
        if (bb <= ss) root = floor_root(rr - (ss - bb));
        else          root = floor_root(rr + (bb - ss));
        k = -b;
        k = (k >= root) ? k - root : 0;
        if (k > d)
            return mk_point(t[0], t[1], t[2], mv.tw, OC_SHORT);
        for (int i = 0; i < 3; i++)
            p[i] = (dv[i] * longint'(k)) / longint'(d) + s[i];
        return mk_point(p[0], p[1], p[2], 0, OC_HIT);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(int mag);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 31'($urandom());
        if (sel == 1) return (($urandom_range(0, 1) != 0) ? 31'h3FFF_FFFF : 31'h4000_0001);
        return $signed(31'($urandom_range(0, 2 * mag))) - 31'(mag);
    endfunction

    function automatic t_move rand_move();
        t_move mv;
        int mag;
        case ($urandom_range(0, 3))
            0: mag = 100;
            1: mag = 100000;
            2: mag = 50000000;
            default: mag = 1073741823;
        endcase
        mv.sx = rand_coord(mag); mv.sy = rand_coord(mag); mv.sz = rand_coord(mag);
        if ($urandom_range(0, 15) == 0) begin
            mv.tx = mv.sx; mv.ty = mv.sy; mv.tz = mv.sz;
        end else begin
            mv.tx = rand_coord(mag); mv.ty = rand_coord(mag); mv.tz = rand_coord(mag);
        end
        mv.tw = $urandom();
        case ($urandom_range(0, 4))
            0: mv.r = 30'($urandom());
            1: mv.r = 30'($urandom_range(0, 64));
            default: mv.r = 30'($urandom_range(0, mag));
        endcase
        return mv;
    endfunction

    function automatic t_move mv_of(longint sx, longint sy, longint sz, longint tx,
                                    longint ty, longint tz, longint tw, longint r);
        t_move mv;
        mv.sx = sx[30:0]; mv.sy = sy[30:0]; mv.sz = sz[30:0];
        mv.tx = tx[30:0]; mv.ty = ty[30:0]; mv.tz = tz[30:0];
        mv.tw = tw[31:0]; mv.r = r[29:0];
        return mv;
    endfunction

    t_row rows[$];

    task automatic add_row(t_move mv, bit typed, t_point res);
        t_row row;
        row.mv = mv;
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endtask

    task automatic send_move(t_move mv, t_point res);
        in_ch.valid    <= 1'b1;
        in_ch.start_x  <= mv.sx;
        in_ch.start_y  <= mv.sy;
        in_ch.start_z  <= mv.sz;
        in_ch.target_x <= mv.tx;
        in_ch.target_y <= mv.ty;
        in_ch.target_z <= mv.tz;
        in_ch.target_w <= mv.tw;
        in_ch.radius   <= mv.r;
        do @(posedge i_clk); while (!in_ch.ready);
        clip_queue.push_back(res);
    endtask

    task automatic gap();
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    initial begin
        t_move mv;
        t_point none;
        int burst;
        bit paused;
        none = '0;
        paused = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.start_x, in_ch.start_y, in_ch.start_z} = '0;
        {in_ch.target_x, in_ch.target_y, in_ch.target_z} = '0;
        in_ch.target_w = '0;
        in_ch.radius = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(mv_of(5, -6, 7, 5, -6, 7, 99, 100), 1, mk_point(5, -6, 7, 0, OC_SAME));
        add_row(mv_of(-1073741824, -1073741824, -1073741824, -1073741824, -1073741824,
                      -1073741824, -1, 1073741823), 1,
                mk_point(-1073741824, -1073741824, -1073741824, 0, OC_SAME));
        add_row(mv_of(3, 4, 0, 100, 0, 0, 7, 1000), 1, mk_point(3, 4, 0, 0, OC_NEAR));
        add_row(mv_of(0, 0, 0, 1, 0, 0, 7, 1), 1, mk_point(0, 0, 0, 0, OC_NEAR));
        add_row(mv_of(500, 0, 0, 0, 0, 900, 7, 1000), 1, mk_point(1000, 0, 0, 0, OC_PROJ));
        add_row(mv_of(2000, 0, 0, 3000, 0, 0, 7, 1000), 1,
                mk_point(3000, 0, 0, 0, OC_OUTWARD));
        add_row(mv_of(2000, 5000, 0, -2000, 5000, 0, -5, 1000), 1,
                mk_point(-2000, 5000, 0, -5, OC_MISS));
        add_row(mv_of(5000, 0, 0, 4000, 0, 0, 123, 1000), 1,
                mk_point(4000, 0, 0, 123, OC_SHORT));
        add_row(mv_of(5000, 0, 0, 0, 0, 0, 123, 1000), 1, mk_point(1000, 0, 0, 0, OC_HIT));
        add_row(mv_of(5, 0, 0, -5, 0, 0, 1, 0), 1, mk_point(0, 0, 0, 0, OC_HIT));
        add_row(mv_of(1073741823, 1073741823, 1073741823, -1073741824, -1073741824,
                      -1073741824, -2147483648, 1073741823), 0, none);
        add_row(mv_of(-1073741824, 0, 0, 1073741823, 0, 0, 2147483647, 0), 0, none);
        add_row(mv_of(1073741823, -1073741824, 1073741823, 0, 0, 0, 0, 1073741823), 0, none);
        add_row(mv_of(40, 0, 0, 41, 0, 0, 0, 32), 0, none);
        add_row(mv_of(31, 0, 0, 0, 5, 0, 0, 1073741823), 0, none);
        add_row(mv_of(100, 100, 100, -100, -99, -98, 3, 170), 0, none);
        add_row(mv_of(-1000000, 3, 7, 1000000, 3, 7, 9, 5), 0, none);

        foreach (rows[i])
            send_move(rows[i].mv, rows[i].typed ? rows[i].res : clip_move(rows[i].mv));
        gap();

        for (int n = 0; n < N_RANDOM; ) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 20);
            for (int j = 0; j < burst && n < N_RANDOM; j++, n++) begin
                if (!paused && n >= N_RANDOM / 2) begin
                    paused = 1'b1;
                    in_ch.valid <= 1'b0;
                    wait (clip_queue.size() == 0);
                    @(posedge i_clk);
                end
                mv = rand_move();
                send_move(mv, clip_move(mv));
            end
            gap();
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (($urandom_range(0, 3000) + $time / 37000) % 4)
                0: out_ch.ready <= ($urandom_range(0, 3) != 0);
                1: out_ch.ready <= ($urandom_range(0, 9) == 0);
                default: out_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (clip_queue.size() == 0) begin
                $error("unexpected result transfer");
                n_errors++;
            end else begin
                want = clip_queue.pop_front();
                if (out_ch.out_x !== want.x) begin
                    $error("out_x expected %0d actual %0d", want.x, out_ch.out_x);
                    n_errors++;
                end
                if (out_ch.out_y !== want.y) begin
                    $error("out_y expected %0d actual %0d", want.y, out_ch.out_y);
                    n_errors++;
                end
                if (out_ch.out_z !== want.z) begin
                    $error("out_z expected %0d actual %0d", want.z, out_ch.out_z);
                    n_errors++;
                end
                if (out_ch.out_w !== want.w) begin
                    $error("out_w expected %0d actual %0d", want.w, out_ch.out_w);
                    n_errors++;
                end
                if (out_ch.outcome !== want.oc) begin
                    $error("outcome expected %0d actual %0d", want.oc, out_ch.outcome);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stim_done && clip_queue.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WDOG_MAX);
        $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
